// ===== design/pwmb_pkg.sv =====
// Shared types and constants for the pulse width mark and bit classifier.
`default_nettype none
package pwmb_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned MARK_W   = 4;
    localparam int unsigned BLOCK_W  = 8;
    localparam int unsigned CFG_IDX_W = 2;

    typedef enum logic [1:0] {
        PK_GLITCH = 2'd0,
        PK_MARK   = 2'd1,
        PK_DATA   = 2'd2,
        PK_EARLY  = 2'd3
    } t_pulse_kind;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_GLITCH_LIMIT = 2'd0,
        CFG_MARK_MIN     = 2'd1,
        CFG_BIT_SPLIT    = 2'd2,
        CFG_MARKS_FINISH = 2'd3
    } t_cfg_index;

    localparam logic [TIME_W-1:0] RST_GLITCH_LIMIT = 32'd20;
    localparam logic [TIME_W-1:0] RST_MARK_MIN     = 32'd2000;
    localparam logic [TIME_W-1:0] RST_BIT_SPLIT    = 32'd300;
    localparam logic [MARK_W-1:0] RST_MARKS_FINISH = 4'd4;

    // One classified pulse handed from the front to the back.
    typedef struct packed {
        t_pulse_kind       kind;
        logic [TIME_W-1:0] width;
        logic [MARK_W-1:0] mark_index;
        logic              done;
    } t_pulse_item;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic not_empty;
    } t_queue_status;

endpackage
`default_nettype wire

// ===== design/pwmb_front.sv =====
// Front end: edge tracking, width measurement, glitch, mark, data and early classification.
`default_nettype none
module pwmb_front (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire logic                         i_fire,
    input  wire logic [pwmb_pkg::TIME_W-1:0]  i_edge_time_us,
    input  wire logic                         i_edge_level,
    input  wire logic [pwmb_pkg::TIME_W-1:0]  i_glitch_limit_us,
    input  wire logic [pwmb_pkg::TIME_W-1:0]  i_mark_min_us,
    input  wire logic [pwmb_pkg::MARK_W-1:0]  i_marks_to_finish,
    output logic                              o_push,
    output pwmb_pkg::t_pulse_item             o_item
);

    logic [pwmb_pkg::TIME_W-1:0] r_rise_time, n_rise_time;
    logic                        r_rise_seen, n_rise_seen;
    logic                        r_started, n_started;
    logic                        r_finished, n_finished;
    logic [pwmb_pkg::MARK_W-1:0] r_mark_count, n_mark_count;

    logic [pwmb_pkg::TIME_W-1:0] width;
    logic [pwmb_pkg::MARK_W-1:0] mark_inc;
    logic                        is_glitch;
    logic                        is_mark;
    logic                        reach_done;

    assign width      = i_edge_time_us - r_rise_time;
    assign is_glitch  = width <= i_glitch_limit_us;
    assign is_mark    = width >= i_mark_min_us;
    assign mark_inc   = (r_mark_count != '1) ? r_mark_count + 1'b1 : r_mark_count;
    assign reach_done = mark_inc >= i_marks_to_finish;

    always_comb begin
        n_rise_time  = r_rise_time;
        n_rise_seen  = r_rise_seen;
        n_started    = r_started;
        n_finished   = r_finished;
        n_mark_count = r_mark_count;
        o_push       = 1'b0;
        o_item.kind       = pwmb_pkg::PK_EARLY;
        o_item.width      = width;
        o_item.mark_index = r_mark_count;
        o_item.done       = 1'b0;
        if (i_fire && !r_finished) begin
            if (i_edge_level) begin
                n_rise_time = i_edge_time_us;
                n_rise_seen = 1'b1;
            end else if (r_rise_seen) begin
                n_rise_seen = 1'b0;
                o_push      = 1'b1;
                if (is_glitch) begin
                    o_item.kind = pwmb_pkg::PK_GLITCH;
                end else if (is_mark) begin
                    o_item.kind       = pwmb_pkg::PK_MARK;
                    o_item.mark_index = mark_inc;
                    o_item.done       = reach_done;
                    n_mark_count      = mark_inc;
                    n_started         = 1'b1;
                    n_finished        = reach_done;
                end else if (!r_started) begin
                    o_item.kind = pwmb_pkg::PK_EARLY;
                end else begin
                    o_item.kind = pwmb_pkg::PK_DATA;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rise_time  <= '0;
            r_rise_seen  <= 1'b0;
            r_started    <= 1'b0;
            r_finished   <= 1'b0;
            r_mark_count <= '0;
        end else begin
            r_rise_time  <= n_rise_time;
            r_rise_seen  <= n_rise_seen;
            r_started    <= n_started;
            r_finished   <= n_finished;
            r_mark_count <= n_mark_count;
        end
    end

endmodule
`default_nettype wire

// ===== design/pwmb_queue.sv =====
// Short queue of classified pulses between the front and the back.
`default_nettype none
module pwmb_queue #(
    parameter int unsigned DEPTH = 2
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_push,
    input  wire pwmb_pkg::t_pulse_item  i_item,
    input  wire logic                   i_pop,
    output pwmb_pkg::t_pulse_item       o_item,
    output pwmb_pkg::t_queue_status     o_status
);

    localparam int unsigned PTR_W = $clog2(DEPTH);
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

    pwmb_pkg::t_pulse_item r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr, n_rd_ptr;
    logic [CNT_W-1:0] r_count, n_count;

    assign o_status.full      = r_count == FULL_COUNT;
    assign o_status.not_empty = r_count != '0;
    assign o_item             = r_mem[r_rd_ptr];

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == LAST) ? '0 : r_wr_ptr + 1'b1;
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == LAST) ? '0 : r_rd_ptr + 1'b1;
        end
        if (i_push && !i_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && i_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef SYNTH
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_status.full |-> !i_push)
        else $error("Pulse written into a full queue.");

    a_no_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_status.not_empty |-> !i_pop)
        else $error("Pulse taken from an empty queue.");

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= FULL_COUNT)
        else $error("Queue count beyond its depth.");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> r_count == $past(r_count) + 1'b1)
        else $error("Queue count did not follow a lone write.");
`endif

endmodule
`default_nettype wire

// ===== design/pwmb_back.sv =====
// Back end: bit decoding, block tracking, running totals and the result register.
`default_nettype none
module pwmb_back (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire pwmb_pkg::t_pulse_item         i_item,
    input  wire pwmb_pkg::t_queue_status       i_status,
    input  wire logic [pwmb_pkg::TIME_W-1:0]   i_bit_split_us,
    input  wire logic                          i_out_stall,
    output logic                               o_pop,
    output logic                               o_out_valid,
    output logic [1:0]                         o_pulse_kind,
    output logic                               o_bit_value,
    output logic [pwmb_pkg::TIME_W-1:0]        o_pulse_width_us,
    output logic                               o_block_start,
    output logic [pwmb_pkg::BLOCK_W-1:0]       o_block_index,
    output logic [pwmb_pkg::MARK_W-1:0]        o_mark_index,
    output logic                               o_capture_done,
    output logic [pwmb_pkg::TIME_W-1:0]        o_bit_total,
    output logic [pwmb_pkg::TIME_W-1:0]        o_glitch_total
);

    logic                         r_valid;
    logic                         r_block_open, n_block_open;
    logic [pwmb_pkg::BLOCK_W-1:0] r_block_count, n_block_count;
    logic [pwmb_pkg::TIME_W-1:0]  r_bit_count, n_bit_count;
    logic [pwmb_pkg::TIME_W-1:0]  r_glitch_count, n_glitch_count;
    logic                         n_start;
    logic                         n_bit;

    logic [1:0]                   r_kind;
    logic                         r_bit;
    logic [pwmb_pkg::TIME_W-1:0]  r_width;
    logic                         r_start;
    logic [pwmb_pkg::MARK_W-1:0]  r_mark_index;
    logic                         r_done;

    assign o_pop = i_status.not_empty && (!r_valid || !i_out_stall);

    always_comb begin
        n_block_open   = r_block_open;
        n_block_count  = r_block_count;
        n_bit_count    = r_bit_count;
        n_glitch_count = r_glitch_count;
        n_start        = 1'b0;
        n_bit          = 1'b0;
        case (i_item.kind)
            pwmb_pkg::PK_GLITCH: begin
                if (r_glitch_count != '1) begin
                    n_glitch_count = r_glitch_count + 1'b1;
                end
            end
            pwmb_pkg::PK_MARK: begin
                n_block_open = 1'b0;
            end
            pwmb_pkg::PK_DATA: begin
                n_bit = i_item.width >= i_bit_split_us;
                if (r_bit_count != '1) begin
                    n_bit_count = r_bit_count + 1'b1;
                end
                if (!r_block_open) begin
                    n_block_open = 1'b1;
                    n_start      = 1'b1;
                    if (r_block_count != '1) begin
                        n_block_count = r_block_count + 1'b1;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid        <= 1'b0;
            r_block_open   <= 1'b0;
            r_block_count  <= '0;
            r_bit_count    <= '0;
            r_glitch_count <= '0;
        end else begin
            if (o_pop) begin
                r_valid        <= 1'b1;
                r_block_open   <= n_block_open;
                r_block_count  <= n_block_count;
                r_bit_count    <= n_bit_count;
                r_glitch_count <= n_glitch_count;
            end else if (!i_out_stall) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_kind       <= i_item.kind;
            r_bit        <= n_bit;
            r_width      <= i_item.width;
            r_start      <= n_start;
            r_mark_index <= i_item.mark_index;
            r_done       <= i_item.done;
        end
    end

    assign o_out_valid      = r_valid;
    assign o_pulse_kind     = r_kind;
    assign o_bit_value      = r_bit;
    assign o_pulse_width_us = r_width;
    assign o_block_start    = r_start;
    assign o_block_index    = r_block_count;
    assign o_mark_index     = r_mark_index;
    assign o_capture_done   = r_done;
    assign o_bit_total      = r_bit_count;
    assign o_glitch_total   = r_glitch_count;

`ifndef SYNTH
    a_hold_stalled: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && i_out_stall) |=> r_valid && $stable(r_bit_count) && $stable(r_width))
        else $error("Stalled result changed.");

    a_start_is_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_start) |-> r_kind == pwmb_pkg::PK_DATA && r_block_open)
        else $error("Block start on a pulse that is no data bit.");

    a_done_is_mark: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_done) |-> r_kind == pwmb_pkg::PK_MARK)
        else $error("Capture finished on a pulse that is no mark.");
`endif

endmodule
`default_nettype wire

// ===== design/pulse_width_mark_bit_classifier_core.sv =====
// Top level of the pulse width mark and bit classifier.
//
//  channel   direction  handshake                 payload
//  edge in   input      i_in_valid / o_in_stall   i_edge_time_us, i_edge_level
//  pulse out output     o_out_valid / i_out_stall pulse kind, width, indexes, totals
//  config    input      i_cfg_we                  i_cfg_index, i_cfg_data
//
// One edge beat is accepted per cycle while the pulse queue has room.
// A measured pulse is written into the queue, then registered at the output when the back pops it.
// The front tracks edges and marks; the back keeps totals behind a QUEUE_DEPTH queue.
// A stalled output holds its beat; the front keeps taking beats until the queue fills.
// Reset is synchronous and restores the configuration defaults.
`default_nettype none
module pulse_width_mark_bit_classifier_core #(
    parameter int unsigned QUEUE_DEPTH = 2
) (
    input  wire logic                            i_clk,
    input  wire logic                            i_rst_n,
    input  wire logic                            i_in_valid,
    output logic                                 o_in_stall,
    input  wire logic [pwmb_pkg::TIME_W-1:0]     i_edge_time_us,
    input  wire logic                            i_edge_level,
    output logic                                 o_out_valid,
    input  wire logic                            i_out_stall,
    output logic [1:0]                           o_pulse_kind,
    output logic                                 o_bit_value,
    output logic [pwmb_pkg::TIME_W-1:0]          o_pulse_width_us,
    output logic                                 o_block_start,
    output logic [pwmb_pkg::BLOCK_W-1:0]         o_block_index,
    output logic [pwmb_pkg::MARK_W-1:0]          o_mark_index,
    output logic                                 o_capture_done,
    output logic [pwmb_pkg::TIME_W-1:0]          o_bit_total,
    output logic [pwmb_pkg::TIME_W-1:0]          o_glitch_total,
    input  wire logic                            i_cfg_we,
    input  wire logic [pwmb_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [pwmb_pkg::TIME_W-1:0]     i_cfg_data
);

    logic [pwmb_pkg::TIME_W-1:0] r_glitch_limit;
    logic [pwmb_pkg::TIME_W-1:0] r_mark_min;
    logic [pwmb_pkg::TIME_W-1:0] r_bit_split;
    logic [pwmb_pkg::MARK_W-1:0] r_marks_finish;

    logic                    fire;
    logic                    push;
    logic                    pop;
    pwmb_pkg::t_pulse_item   front_item;
    pwmb_pkg::t_pulse_item   head_item;
    pwmb_pkg::t_queue_status status;

    assign o_in_stall = status.full;
    assign fire       = i_in_valid && !status.full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_glitch_limit <= pwmb_pkg::RST_GLITCH_LIMIT;
            r_mark_min     <= pwmb_pkg::RST_MARK_MIN;
            r_bit_split    <= pwmb_pkg::RST_BIT_SPLIT;
            r_marks_finish <= pwmb_pkg::RST_MARKS_FINISH;
        end else if (i_cfg_we) begin
            case (pwmb_pkg::t_cfg_index'(i_cfg_index))
                pwmb_pkg::CFG_GLITCH_LIMIT: r_glitch_limit <= i_cfg_data;
                pwmb_pkg::CFG_MARK_MIN:     r_mark_min     <= i_cfg_data;
                pwmb_pkg::CFG_BIT_SPLIT:    r_bit_split    <= i_cfg_data;
                pwmb_pkg::CFG_MARKS_FINISH: r_marks_finish <= i_cfg_data[pwmb_pkg::MARK_W-1:0];
                default: begin
                end
            endcase
        end
    end

    pwmb_front u_front (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_fire            (fire),
        .i_edge_time_us    (i_edge_time_us),
        .i_edge_level      (i_edge_level),
        .i_glitch_limit_us (r_glitch_limit),
        .i_mark_min_us     (r_mark_min),
        .i_marks_to_finish (r_marks_finish),
        .o_push            (push),
        .o_item            (front_item)
    );

    pwmb_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_item   (front_item),
        .i_pop    (pop),
        .o_item   (head_item),
        .o_status (status)
    );

    pwmb_back u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_item           (head_item),
        .i_status         (status),
        .i_bit_split_us   (r_bit_split),
        .i_out_stall      (i_out_stall),
        .o_pop            (pop),
        .o_out_valid      (o_out_valid),
        .o_pulse_kind     (o_pulse_kind),
        .o_bit_value      (o_bit_value),
        .o_pulse_width_us (o_pulse_width_us),
        .o_block_start    (o_block_start),
        .o_block_index    (o_block_index),
        .o_mark_index     (o_mark_index),
        .o_capture_done   (o_capture_done),
        .o_bit_total      (o_bit_total),
        .o_glitch_total   (o_glitch_total)
    );

endmodule
`default_nettype wire

// ===== verif/pwmb_pulse_checker.sv =====
// Predictor and beat checker for the pulse width mark and bit classifier.
module pwmb_pulse_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    input  logic                          i_in_stall,
    input  logic [31:0]                   i_edge_time_us,
    input  logic                          i_edge_level,
    input  logic                          i_cfg_we,
    input  pwmb_pkg::t_cfg_index          i_cfg_index,
    input  logic [31:0]                   i_cfg_data,
    input  logic                          i_out_valid,
    input  logic                          i_out_stall,
    input  logic [1:0]                    i_pulse_kind,
    input  logic                          i_bit_value,
    input  logic [31:0]                   i_pulse_width_us,
    input  logic                          i_block_start,
    input  logic [7:0]                    i_block_index,
    input  logic [3:0]                    i_mark_index,
    input  logic                          i_capture_done,
    input  logic [31:0]                   i_bit_total,
    input  logic [31:0]                   i_glitch_total,
    output int                            o_fail_count,
    output int                            o_pending
);

    typedef struct packed {
        pwmb_pkg::t_pulse_kind kind;
        logic        bit_value;
        logic [31:0] width;
        logic        block_start;
        logic [7:0]  block_index;
        logic [3:0]  mark_index;
        logic        capture_done;
        logic [31:0] bit_total;
        logic [31:0] glitch_total;
    } t_pulse_rec;

    t_pulse_rec  expected_pulses[$];
    int          fails = 0;

    logic [31:0] cfg_glitch;
    logic [31:0] cfg_mark;
    logic [31:0] cfg_split;
    logic [3:0]  cfg_finish;

    logic [31:0] up_time;
    logic        up_pending;
    logic        started;
    logic        block_open;
    logic [3:0]  marks;
    logic [7:0]  blocks;
    logic [31:0] bits;
    logic [31:0] glitches;
    logic        halted;

    initial begin
        o_fail_count = 0;
        o_pending = 0;
    end

    task automatic restore_defaults();
        cfg_glitch = pwmb_pkg::RST_GLITCH_LIMIT;
        cfg_mark   = pwmb_pkg::RST_MARK_MIN;
        cfg_split  = pwmb_pkg::RST_BIT_SPLIT;
        cfg_finish = pwmb_pkg::RST_MARKS_FINISH;
        up_time    = '0;
        up_pending = 1'b0;
        started    = 1'b0;
        block_open = 1'b0;
        marks      = '0;
        blocks     = '0;
        bits       = '0;
        glitches   = '0;
        halted     = 1'b0;
        expected_pulses.delete();
    endtask

    task automatic classify_edge(input logic [31:0] stamp, input logic lvl);
        t_pulse_rec  rec;
        logic [31:0] span;
        if (halted) return;
        if (lvl) begin
            up_time = stamp;
            up_pending = 1'b1;
            return;
        end
        if (!up_pending) return;
        up_pending = 1'b0;
        span = stamp - up_time;
        rec = '0;
        rec.width = span;
        if (span <= cfg_glitch) begin
            rec.kind = pwmb_pkg::PK_GLITCH;
            if (glitches != 32'hFFFF_FFFF) glitches = glitches + 32'd1;
        end else if (span >= cfg_mark) begin
            rec.kind = pwmb_pkg::PK_MARK;
            if (marks != 4'hF) marks = marks + 4'd1;
            started = 1'b1;
            block_open = 1'b0;
            if (marks >= cfg_finish) begin
                halted = 1'b1;
                rec.capture_done = 1'b1;
            end
        end else if (!started) begin
            rec.kind = pwmb_pkg::PK_EARLY;
        end else begin
            rec.kind = pwmb_pkg::PK_DATA;
            if (bits != 32'hFFFF_FFFF) bits = bits + 32'd1;
            if (!block_open) begin
                block_open = 1'b1;
                rec.block_start = 1'b1;
                if (blocks != 8'hFF) blocks = blocks + 8'd1;
            end
            rec.bit_value = (span >= cfg_split);
        end
        rec.block_index  = blocks;
        rec.mark_index   = marks;
        rec.bit_total    = bits;
        rec.glitch_total = glitches;
        expected_pulses.push_back(rec);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            fails++;
        end
    endtask

    task automatic compare_pulse();
        t_pulse_rec rec;
        if (expected_pulses.size() == 0) begin
            $display("%0t: unexpected pulse beat, expected none, actual kind %0d width %0h",
                     $time, i_pulse_kind, i_pulse_width_us);
            fails++;
            return;
        end
        rec = expected_pulses.pop_front();
        check_field("pulse_kind", 32'(rec.kind), 32'(i_pulse_kind));
        check_field("bit_value", 32'(rec.bit_value), 32'(i_bit_value));
        check_field("pulse_width_us", rec.width, i_pulse_width_us);
        check_field("block_start", 32'(rec.block_start), 32'(i_block_start));
        check_field("block_index", 32'(rec.block_index), 32'(i_block_index));
        check_field("mark_index", 32'(rec.mark_index), 32'(i_mark_index));
        check_field("capture_done", 32'(rec.capture_done), 32'(i_capture_done));
        check_field("bit_total", rec.bit_total, i_bit_total);
        check_field("glitch_total", rec.glitch_total, i_glitch_total);
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            restore_defaults();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    pwmb_pkg::CFG_GLITCH_LIMIT: cfg_glitch = i_cfg_data;
                    pwmb_pkg::CFG_MARK_MIN:     cfg_mark = i_cfg_data;
                    pwmb_pkg::CFG_BIT_SPLIT:    cfg_split = i_cfg_data;
                    pwmb_pkg::CFG_MARKS_FINISH: cfg_finish = i_cfg_data[3:0];
                    default:          ;
                endcase
            end
            if (i_in_valid && !i_in_stall) classify_edge(i_edge_time_us, i_edge_level);
            if (i_out_valid && !i_out_stall) compare_pulse();
        end
        o_pending <= expected_pulses.size();
        o_fail_count <= fails;
    end

endmodule

// ===== verif/pulse_width_mark_bit_classifier_core_tb.sv =====
// Stimulus and verdict for the pulse width mark and bit classifier.
module pulse_width_mark_bit_classifier_core_tb;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [31:0] edge_time = '0;
    logic        edge_level = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [1:0]  pulse_kind;
    logic        bit_value;
    logic [31:0] pulse_width;
    logic        block_start;
    logic [7:0]  block_index;
    logic [3:0]  mark_index;
    logic        capture_done;
    logic [31:0] bit_total;
    logic [31:0] glitch_total;
    logic        cfg_we = 1'b0;
    pwmb_pkg::t_cfg_index cfg_index = pwmb_pkg::CFG_GLITCH_LIMIT;
    logic [31:0] cfg_data = '0;

    int          fail_count;
    int          pending;

    int          items_sent = 0;
    int          marks_used = 0;
    int          idle_pct = 0;
    logic        calm = 1'b0;
    int          stall_left = 0;
    logic [15:0] stall_cyc = '0;
    logic [31:0] last_fall = '0;
    logic [31:0] cur_gl = pwmb_pkg::RST_GLITCH_LIMIT;
    logic [31:0] cur_mm = pwmb_pkg::RST_MARK_MIN;
    logic [31:0] cur_bs = pwmb_pkg::RST_BIT_SPLIT;

    pulse_width_mark_bit_classifier_core i_dut (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .o_in_stall       (in_stall),
        .i_edge_time_us   (edge_time),
        .i_edge_level     (edge_level),
        .o_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .o_pulse_kind     (pulse_kind),
        .o_bit_value      (bit_value),
        .o_pulse_width_us (pulse_width),
        .o_block_start    (block_start),
        .o_block_index    (block_index),
        .o_mark_index     (mark_index),
        .o_capture_done   (capture_done),
        .o_bit_total      (bit_total),
        .o_glitch_total   (glitch_total),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data)
    );

    pwmb_pulse_checker u_pulse_check (
        .i_clk            (clk),
        .i_rst_n          (rst_n),
        .i_in_valid       (in_valid),
        .i_in_stall       (in_stall),
        .i_edge_time_us   (edge_time),
        .i_edge_level     (edge_level),
        .i_cfg_we         (cfg_we),
        .i_cfg_index      (cfg_index),
        .i_cfg_data       (cfg_data),
        .i_out_valid      (out_valid),
        .i_out_stall      (out_stall),
        .i_pulse_kind     (pulse_kind),
        .i_bit_value      (bit_value),
        .i_pulse_width_us (pulse_width),
        .i_block_start    (block_start),
        .i_block_index    (block_index),
        .i_mark_index     (mark_index),
        .i_capture_done   (capture_done),
        .i_bit_total      (bit_total),
        .i_glitch_total   (glitch_total),
        .o_fail_count     (fail_count),
        .o_pending        (pending)
    );

    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk) begin
        stall_cyc <= stall_cyc + 16'd1;
        if (calm || !rst_n) begin
            out_stall <= 1'b0;
            stall_left <= 0;
        end else if (stall_left != 0) begin
            out_stall <= 1'b1;
            stall_left <= stall_left - 1;
        end else if (!stall_cyc[8] && $urandom_range(0, 5) == 0) begin
            out_stall <= 1'b1;
            stall_left <= $urandom_range(0, 7);
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic send_edge(input logic [31:0] stamp, input logic lvl);
        if (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        in_valid <= 1'b1;
        edge_time <= stamp;
        edge_level <= lvl;
        do @(posedge clk); while (in_stall);
        items_sent++;
    endtask

    task automatic send_pulse(input logic [31:0] rise, input logic [31:0] fall);
        send_edge(rise, 1'b1);
        send_edge(fall, 1'b0);
        last_fall = fall;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input pwmb_pkg::t_cfg_index idx, input logic [31:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
    endtask

    task automatic set_limits(input logic [31:0] gl, input logic [31:0] mm,
                              input logic [31:0] bs, input logic [3:0] fin);
        write_reg(pwmb_pkg::CFG_GLITCH_LIMIT, gl);
        write_reg(pwmb_pkg::CFG_MARK_MIN, mm);
        write_reg(pwmb_pkg::CFG_BIT_SPLIT, bs);
        write_reg(pwmb_pkg::CFG_MARKS_FINISH, {28'd0, fin});
        cfg_we <= 1'b0;
        cur_gl = gl;
        cur_mm = mm;
        cur_bs = bs;
    endtask

    function automatic longint unsigned pick_width(input longint unsigned lo,
                                                   input longint unsigned hi);
        longint unsigned span;
        longint unsigned bs;
        span = hi - lo + 1;
        bs = 64'(cur_bs);
        case ($urandom_range(0, 7))
            0: return lo;
            1: return hi;
            2: return (span > 4) ? lo + 64'($urandom_range(1, 3)) : lo;
            3: if (bs >= lo && bs <= hi) return bs;
            4: if (bs > lo && bs - 1 <= hi) return bs - 1;
            default: ;
        endcase
        return lo + ({$urandom, $urandom} % span);
    endfunction

    task automatic make_pulse();
        longint unsigned gl;
        longint unsigned mm;
        longint unsigned lo;
        longint unsigned hi;
        longint unsigned w;
        logic [31:0]     rt;
        int              roll;
        gl = 64'(cur_gl);
        mm = 64'(cur_mm);
        roll = $urandom_range(0, 99);
        if (roll < 3 && gl < 64'hFFFF_FFFF && marks_used < 14) begin
            lo = (mm > gl) ? mm : gl + 1;
            hi = 64'hFFFF_FFFF;
            marks_used++;
        end else if (roll < 75 && gl + 2 <= mm) begin
            lo = gl + 1;
            hi = mm - 1;
        end else begin
            lo = 0;
            hi = gl;
        end
        w = pick_width(lo, hi);
        if ($urandom_range(0, 14) == 0) send_edge($urandom, 1'b0);
        rt = ($urandom_range(0, 3) == 0) ? $urandom : last_fall + $urandom_range(1, 5000);
        if ($urandom_range(0, 11) == 0) begin
            send_edge(rt, 1'b1);
            rt = rt + $urandom_range(0, 50);
        end
        send_pulse(rt, rt + w[31:0]);
    endtask

    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    initial begin
        int          p;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
        logic [31:0] tmp;
        logic [3:0]  fin_val;

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        idle_pct = 20;
        send_edge(32'd100, 1'b0);
        send_pulse(32'd0, 32'd0);
        send_edge(32'd1000, 1'b1);
        send_pulse(32'd1005, 32'd1025);
        send_pulse(32'd2000, 32'd2021);
        send_pulse(32'd5000, 32'd6999);
        send_pulse(32'hFFFF_FF00, 32'h0000_07CF);
        send_pulse(32'd8000, 32'd8299);
        send_pulse(32'd9000, 32'd9300);
        send_pulse(32'd10000, 32'd12000);
        send_pulse(32'd13000, 32'd13021);
        send_pulse(32'hFFFF_FFFF, 32'h0000_07CE);
        marks_used = 2;

        for (p = 0; p < 8; p++) begin
            wait_idle();
            case (p)
                0: set_limits($urandom_range(0, 40), $urandom_range(1000, 4000),
                              $urandom_range(100, 600), 4'd15);
                1: set_limits(32'd0, 32'hFFFF_FFFF, 32'd0, 4'd15);
                2: set_limits(32'd0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd15);
                3: set_limits(32'hFFFF_FFFF, $urandom, $urandom, 4'd15);
                4: set_limits($urandom_range(0, 40), 32'd0, $urandom_range(0, 600), 4'd15);
                5: set_limits($urandom, $urandom, $urandom, 4'd15);
                6: begin
                    a = $urandom;
                    b = $urandom;
                    c = $urandom;
                    if (a > b) begin tmp = a; a = b; b = tmp; end
                    if (b > c) begin tmp = b; b = c; c = tmp; end
                    if (a > b) begin tmp = a; a = b; b = tmp; end
                    set_limits(a, c, b, 4'd15);
                end
                default: set_limits(32'd20, 32'd2000, 32'd300, 4'd15);
            endcase
            idle_pct = (p % 3 == 0) ? 0 : ((p % 3 == 1) ? 15 : 35);
            while (items_sent < 22 + (p + 1) * 116) make_pulse();
        end

        wait_idle();
        case ($urandom_range(0, 2))
            0:       fin_val = 4'd0;
            1:       fin_val = 4'd1;
            default: fin_val = 4'(marks_used + 1);
        endcase
        set_limits(32'd20, 32'd2000, 32'd300, fin_val);
        calm <= 1'b1;
        idle_pct = 0;
        send_pulse(last_fall + 100, last_fall + 250);
        send_pulse(last_fall + 100, last_fall + 500);
        send_pulse(last_fall + 100, last_fall + 110);
        send_pulse(last_fall + 100, last_fall + 2600);
        send_edge(last_fall + 100, 1'b1);
        send_edge(last_fall + 150, 1'b0);
        send_edge(last_fall + 200, 1'b1);
        send_edge(last_fall + 2500, 1'b0);
        wait_idle();
        repeat (4) @(posedge clk);

        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
design/pwmb_pkg.sv
design/pwmb_front.sv
design/pwmb_queue.sv
design/pwmb_back.sv
design/pulse_width_mark_bit_classifier_core.sv
verif/pwmb_pulse_checker.sv
verif/pulse_width_mark_bit_classifier_core_tb.sv
